FILE: design/cet_pkg.sv
// ----------------------------------------------------------------------------
// cet_pkg
// Shared types, constants and calendar tables for the elapsed time block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cet_pkg;

   typedef enum logic [2:0] {
      UNIT_MINUTES = 3'd0,
      UNIT_HOURS   = 3'd1,
      UNIT_DAYS    = 3'd2,
      UNIT_MONTHS  = 3'd3,
      UNIT_YEARS   = 3'd4
   } cet_unit_type;

   // delay from an accepted request to its result strobe
   localparam int CET_LATENCY = 5;

   localparam int DOY_W = 9;

   localparam logic [31:0] SAT32          = 32'hFFFF_FFFF;
   localparam logic [31:0] MIN_DAY_LIMIT  = 32'hFFFF_FFFF / 24 / 60;
   localparam logic [31:0] HOUR_DAY_LIMIT = 32'hFFFF_FFFF / 24;

   // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x below 2^14
   localparam logic [12:0] RECIP_25    = 13'd5243;
   localparam int          RECIP_SHIFT = 17;

   localparam logic [DOY_W-1:0] CUM_PLAIN [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };
   localparam logic [DOY_W-1:0] CUM_LEAP [12] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
   };

   typedef struct packed {
      cet_unit_type unit;
      logic         date_lt;
      logic         zero_min;
      logic         zero_hr;
      logic         borrow;
      logic         coarse_sat;
      logic [4:0]   start_hour;
      logic [4:0]   end_hour;
      logic [5:0]   start_minute;
      logic [5:0]   end_minute;
   } cet_ctrl_type;

   // month 0 reads as january, 13 to 15 as december
   function automatic logic [3:0] month_index(input logic [3:0] month);
      logic [3:0] idx;
      if (month == 4'd0) begin
         idx = 4'd0;
      end else if (month > 4'd12) begin
         idx = 4'd11;
      end else begin
         idx = month - 4'd1;
      end
      return idx;
   endfunction

   function automatic logic [DOY_W-1:0] cum_days(input logic leap, input logic [3:0] idx);
      logic [DOY_W-1:0] val;
      if (leap) begin
         val = CUM_LEAP[idx];
      end else begin
         val = CUM_PLAIN[idx];
      end
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: design/cet_year_unit.sv
// ----------------------------------------------------------------------------
// cet_year_unit
// Two-stage day count of one timestamp: days before its year (leap aware)
// and day of year, from the cumulative month tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cet_year_unit #(
   parameter int YW = 16
) (
   input  wire logic                       clock,
   input  wire logic [YW-1:0]              year,
   input  wire logic [3:0]                 month,
   input  wire logic [4:0]                 day,
   output logic      [YW+8:0]              year_base,
   output logic      [cet_pkg::DOY_W-1:0]  day_of_year
);
   import cet_pkg::*;

   localparam int Q4W   = YW - 2;
   localparam int Q100W = YW - 6;
   localparam int PW    = Q4W + 13;
   localparam int HW    = YW + 9;

   logic [PW-1:0]    prod;
   logic [Q100W-1:0] q100_in;
   logic [YW-1:0]    year_ff;
   logic [Q100W-1:0] q100_ff;
   logic [3:0]       idx_ff;
   logic [4:0]       day_ff;

   logic [Q4W-1:0]   q4b;
   logic [Q4W-1:0]   q100x25;
   logic [Q4W-1:0]   rem25;
   logic             leap;
   logic [Q4W-1:0]   leaps;
   logic [HW-1:0]    base_in;
   logic [DOY_W-1:0] doy_in;
   logic [HW-1:0]    base_ff;
   logic [DOY_W-1:0] doy_ff;

   // stage a: year / 100 by reciprocal multiply on year / 4
   assign prod    = PW'(year[YW-1:2]) * PW'(RECIP_25);
   assign q100_in = prod[RECIP_SHIFT +: Q100W];

   always_ff @(posedge clock) begin
      year_ff <= year;
      q100_ff <= q100_in;
      idx_ff  <= month_index(month);
      day_ff  <= day;
   end

   // stage b: leap test and days before the year
   assign q4b     = year_ff[YW-1:2];
   assign q100x25 = Q4W'(q100_ff) * Q4W'(25);
   assign rem25   = q4b - q100x25;
   assign leap    = (year_ff[1:0] == 2'b00) && ((rem25 != '0) || (q100_ff[1:0] == 2'b00));
   assign leaps   = q4b - Q4W'(q100_ff) + Q4W'(q100_ff >> 2);

   // offset by one so that year zero, a leap year, starts at zero
   assign base_in = HW'(year_ff) * HW'(365) + HW'(leaps) + HW'(1) - HW'(leap);
   assign doy_in  = cum_days(leap, idx_ff) + DOY_W'(day_ff);

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      doy_ff  <= doy_in;
   end

   assign year_base   = base_ff;
   assign day_of_year = doy_ff;

endmodule

`default_nettype wire

FILE: design/cet_span_unit.sv
// ----------------------------------------------------------------------------
// cet_span_unit
// Three-stage back end: day span, hour span, minute span with saturation,
// then unit select into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cet_span_unit #(
   parameter int YW = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire cet_pkg::cet_ctrl_type      ctrl,
   input  wire logic [YW+3:0]              coarse,
   input  wire logic [YW+8:0]              start_base,
   input  wire logic [YW+8:0]              end_base,
   input  wire logic [cet_pkg::DOY_W-1:0]  start_doy,
   input  wire logic [cet_pkg::DOY_W-1:0]  end_doy,
   output logic                            out_valid,
   output logic [31:0]                     elapsed
);
   import cet_pkg::*;

   localparam int HW = YW + 9;
   localparam int TW = HW + 6;
   localparam int CW = YW + 4;

   // stage d
   logic [HW+1:0]     diff;
   logic [HW-1:0]     days_in;
   logic [HW-1:0]     days_ff;
   cet_ctrl_type      ctrl_d_ff;
   logic [CW-1:0]     coarse_d_ff;
   logic              valid_d_ff;

   // stage e
   logic              hour_sat;
   logic              min_sat_in;
   logic [TW-1:0]     span_hours;
   logic [31:0]       hours_in;
   logic [31:0]       hours_ff;
   logic [HW-1:0]     days_e_ff;
   logic              min_sat_ff;
   cet_ctrl_type      ctrl_e_ff;
   logic [CW-1:0]     coarse_e_ff;
   logic              valid_e_ff;

   // stage f
   logic [31:0]       hours_base;
   logic [39:0]       scaled;
   logic [40:0]       offset;
   logic [40:0]       mraw;
   logic [31:0]       minutes;
   logic [31:0]       elapsed_in;
   logic [31:0]       elapsed_ff;
   logic              valid_f_ff;

   assign diff = {2'b00, end_base} - {2'b00, start_base}
               + (HW+2)'(end_doy) - (HW+2)'(start_doy);
   assign days_in = (ctrl.date_lt && !diff[HW+1]) ? diff[HW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else begin
         valid_d_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      days_ff     <= days_in;
      ctrl_d_ff   <= ctrl;
      coarse_d_ff <= coarse;
   end

   assign hour_sat   = 32'(days_ff) >= HOUR_DAY_LIMIT;
   assign min_sat_in = 32'(days_ff) >= MIN_DAY_LIMIT;
   assign span_hours = TW'(days_ff) * TW'(24) + TW'(ctrl_d_ff.end_hour);

   always_comb begin
      if (hour_sat) begin
         hours_in = SAT32;
      end else if (span_hours > TW'(ctrl_d_ff.start_hour)) begin
         hours_in = 32'(span_hours - TW'(ctrl_d_ff.start_hour));
      end else begin
         hours_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_e_ff <= 1'b0;
      end else begin
         valid_e_ff <= valid_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      hours_ff    <= hours_in;
      days_e_ff   <= days_ff;
      min_sat_ff  <= min_sat_in;
      ctrl_e_ff   <= ctrl_d_ff;
      coarse_e_ff <= coarse_d_ff;
   end

   // minute borrow takes one hour back, floored at zero
   assign hours_base = (ctrl_e_ff.borrow && hours_ff != '0) ? hours_ff - 32'd1 :
                       (ctrl_e_ff.borrow ? '0 : hours_ff);
   assign scaled = 40'(hours_base) * 40'(60);
   assign offset = ctrl_e_ff.borrow ?
                   41'(ctrl_e_ff.end_minute) + 41'(60) - 41'(ctrl_e_ff.start_minute) :
                   41'(ctrl_e_ff.end_minute) - 41'(ctrl_e_ff.start_minute);
   assign mraw   = {1'b0, scaled} + offset;

   // a negative sum wraps high and saturates as well
   assign minutes = (min_sat_ff || mraw[40] || mraw[39:32] != '0) ? SAT32 : mraw[31:0];

   always_comb begin
      case (ctrl_e_ff.unit)
         UNIT_MINUTES: begin
            elapsed_in = ctrl_e_ff.zero_min ? '0 : minutes;
         end
         UNIT_HOURS: begin
            elapsed_in = ctrl_e_ff.zero_hr ? '0 : hours_ff;
         end
         UNIT_DAYS: begin
            elapsed_in = 32'(days_e_ff);
         end
         UNIT_MONTHS, UNIT_YEARS: begin
            elapsed_in = ctrl_e_ff.coarse_sat ? SAT32 : 32'(coarse_e_ff);
         end
         default: begin
            elapsed_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_f_ff <= 1'b0;
      end else begin
         valid_f_ff <= valid_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
   end

   assign out_valid = valid_f_ff;
   assign elapsed   = elapsed_ff;

endmodule

`default_nettype wire

FILE: design/calendar_elapsed_time.sv
// ----------------------------------------------------------------------------
// calendar_elapsed_time
// Elapsed minutes, hours, days, months or years between two timestamps.
// ----------------------------------------------------------------------------
// throughput: one request per cycle, busy never rises; the result pipe is
//   input register, two year-count stages, day, hour and minute stages
// reset clears the valid pipeline; requests in flight are dropped
// results are strobed for one cycle and cannot be held off by the receiver
`timescale 1ns / 1ps
`default_nettype none

module calendar_elapsed_time #(
   parameter int YEAR_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_start,
   output logic             busy,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [15:0] req_start_year,
   input  wire logic [3:0]  req_start_month,
   input  wire logic [4:0]  req_start_day,
   input  wire logic [4:0]  req_start_hour,
   input  wire logic [5:0]  req_start_minute,
   input  wire logic [15:0] req_end_year,
   input  wire logic [3:0]  req_end_month,
   input  wire logic [4:0]  req_end_day,
   input  wire logic [4:0]  req_end_hour,
   input  wire logic [5:0]  req_end_minute,
   output logic             rsp_valid,
   output logic [31:0]      rsp_elapsed
);
   import cet_pkg::*;

   // years wider than the port are limited to the port
   localparam int YW = (YEAR_BITS < 16) ? YEAR_BITS : 16;
   localparam int CW = YW + 4;

   logic             valid0_ff;
   cet_unit_type     unit_ff;
   logic [YW-1:0]    sy_ff;
   logic [3:0]       sm_ff;
   logic [4:0]       sd_ff;
   logic [4:0]       sh_ff;
   logic [5:0]       smin_ff;
   logic [YW-1:0]    ey_ff;
   logic [3:0]       em_ff;
   logic [4:0]       ed_ff;
   logic [4:0]       eh_ff;
   logic [5:0]       emin_ff;

   logic             date_gt;
   logic             date_eq;
   logic             month_zero;
   logic [YW-1:0]    year_diff;
   logic [CW:0]      month_raw;
   logic [CW-1:0]    coarse_in;
   cet_ctrl_type     ctrl_in;

   cet_ctrl_type     ctrl1_ff;
   cet_ctrl_type     ctrl2_ff;
   logic [CW-1:0]    coarse1_ff;
   logic [CW-1:0]    coarse2_ff;
   logic             valid1_ff;
   logic             valid2_ff;

   logic [YW+8:0]    start_base;
   logic [YW+8:0]    end_base;
   logic [DOY_W-1:0] start_doy;
   logic [DOY_W-1:0] end_doy;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= req_start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff <= cet_unit_type'(req_cmd);
      sy_ff   <= req_start_year[YW-1:0];
      sm_ff   <= req_start_month;
      sd_ff   <= req_start_day;
      sh_ff   <= req_start_hour;
      smin_ff <= req_start_minute;
      ey_ff   <= req_end_year[YW-1:0];
      em_ff   <= req_end_month;
      ed_ff   <= req_end_day;
      eh_ff   <= req_end_hour;
      emin_ff <= req_end_minute;
   end

   // date ordering on raw year, month, day
   assign date_gt = (sy_ff > ey_ff) ||
                    (sy_ff == ey_ff && (sm_ff > em_ff || (sm_ff == em_ff && sd_ff > ed_ff)));
   assign date_eq = (sy_ff == ey_ff) && (sm_ff == em_ff) && (sd_ff == ed_ff);

   // months: borrow from the year folds into one signed sum
   assign month_zero = (sy_ff > ey_ff) || (sy_ff == ey_ff && sm_ff > em_ff);
   assign year_diff  = ey_ff - sy_ff;
   assign month_raw  = (CW+1)'(year_diff) * (CW+1)'(12) + (CW+1)'(em_ff) - (CW+1)'(sm_ff);

   always_comb begin
      if (unit_ff == UNIT_YEARS) begin
         coarse_in = (ey_ff > sy_ff) ? CW'(year_diff) : '0;
      end else begin
         coarse_in = month_zero ? '0 : month_raw[CW-1:0];
      end
   end

   always_comb begin
      ctrl_in.unit         = unit_ff;
      ctrl_in.date_lt      = !date_gt && !date_eq;
      ctrl_in.zero_min     = date_gt ||
                             (date_eq && (sh_ff > eh_ff || (sh_ff == eh_ff && smin_ff > emin_ff)));
      ctrl_in.zero_hr      = date_gt || (date_eq && sh_ff > eh_ff);
      ctrl_in.borrow       = smin_ff > emin_ff;
      ctrl_in.coarse_sat   = (unit_ff == UNIT_MONTHS) && !month_zero && month_raw[CW];
      ctrl_in.start_hour   = sh_ff;
      ctrl_in.end_hour     = eh_ff;
      ctrl_in.start_minute = smin_ff;
      ctrl_in.end_minute   = emin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= valid0_ff;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ctrl1_ff   <= ctrl_in;
      ctrl2_ff   <= ctrl1_ff;
      coarse1_ff <= coarse_in;
      coarse2_ff <= coarse1_ff;
   end

   cet_year_unit #(
      .YW (YW)
   ) u_start_year (
      .clock       (clock),
      .year        (sy_ff),
      .month       (sm_ff),
      .day         (sd_ff),
      .year_base   (start_base),
      .day_of_year (start_doy)
   );

   cet_year_unit #(
      .YW (YW)
   ) u_end_year (
      .clock       (clock),
      .year        (ey_ff),
      .month       (em_ff),
      .day         (ed_ff),
      .year_base   (end_base),
      .day_of_year (end_doy)
   );

   cet_span_unit #(
      .YW (YW)
   ) u_span (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid2_ff),
      .ctrl       (ctrl2_ff),
      .coarse     (coarse2_ff),
      .start_base (start_base),
      .end_base   (end_base),
      .start_doy  (start_doy),
      .end_doy    (end_doy),
      .out_valid  (rsp_valid),
      .elapsed    (rsp_elapsed)
   );

endmodule

`default_nettype wire

FILE: design/cet_checker.sv
// ----------------------------------------------------------------------------
// cet_checker
// Port-level checks of request timing and simple result values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cet_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_start,
   input wire logic        busy,
   input wire logic [2:0]  req_cmd,
   input wire logic [15:0] req_start_year,
   input wire logic [3:0]  req_start_month,
   input wire logic [4:0]  req_start_day,
   input wire logic [15:0] req_end_year,
   input wire logic [3:0]  req_end_month,
   input wire logic [4:0]  req_end_day,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_elapsed
);
   import cet_pkg::*;

   // the check delay also covers the edge at which the strobe is sampled
   localparam int RSP_DELAY = CET_LATENCY + 1;

   logic accept;
   assign accept = req_start && !busy;

   // the pipe never stalls
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##RSP_DELAY rsp_valid)
      else $error("request produced no result");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, RSP_DELAY))
      else $error("result without request");

   a_bad_unit_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd > 3'(UNIT_YEARS)) |-> ##RSP_DELAY (rsp_elapsed == '0))
      else $error("unused unit gave non-zero result");

   a_same_date_days: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == 3'(UNIT_DAYS) && req_start_year == req_end_year &&
       req_start_month == req_end_month && req_start_day == req_end_day)
      |-> ##RSP_DELAY (rsp_elapsed == '0))
      else $error("same date gave non-zero day count");

endmodule

bind calendar_elapsed_time cet_checker u_cet_checker (.*);

`default_nettype wire
